// ----- rtl/qtg_pkg.sv -----
package qtg_pkg;

    // Default build values for the top-level parameters.
    localparam int MAX_POINTS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // Phase is carried with this many fraction bits.
    localparam int TAU_BITS = 32;

    // Internal values are signed 64-bit words saturated to +-(2^61 - 1).
    typedef logic signed [63:0] t_val;
    localparam t_val SAT_MAG = 64'sh1FFF_FFFF_FFFF_FFFF;

    // Largest waypoint time.
    localparam logic [30:0] TIME_MAX = 31'h7FFF_FFFF;

    // Item opcodes.
    localparam logic [1:0] OP_BEGIN  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_EVAL   = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NONPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_FEW    = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_TIME_STEP = 1'b0;
    localparam logic CFG_ABS_TIMES = 1'b1;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [30:0]        time_value;
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] acceleration;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_position;
        logic signed [31:0] out_velocity;
        logic signed [31:0] out_acceleration;
        logic [1:0]         status;
    } t_out;

    // Saturate a wide intermediate to the internal range.
    function automatic t_val f_clamp(input logic signed [69:0] x);
        t_val r;
        if (x > 70'(SAT_MAG)) begin
            r = SAT_MAG;
        end else if (x < -70'(SAT_MAG)) begin
            r = -SAT_MAG;
        end else begin
            r = x[63:0];
        end
        return r;
    endfunction

    // Saturating add.
    function automatic t_val f_sadd(input t_val a, input t_val b);
        return f_clamp(70'(a) + 70'(b));
    endfunction

    // Saturating multiply by a small signed factor.
    function automatic t_val f_smul(input t_val x, input logic signed [5:0] k);
        return f_clamp(70'(x) * 70'(k));
    endfunction

    // Halve, rounding half away from zero.
    function automatic t_val f_half(input t_val x);
        t_val r;
        if (x >= 0) begin
            r = (x + 64'sd1) >>> 1;
        end else begin
            r = -((-x + 64'sd1) >>> 1);
        end
        return r;
    endfunction

    // Saturate to a 32-bit result field.
    function automatic logic signed [31:0] f_out32(input t_val x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Horner chains: 0 position, 1 velocity numerator, 2 acceleration numerator.
    function automatic logic signed [5:0] f_kinit(input logic [1:0] ch);
        logic signed [5:0] k;
        case (ch)
            2'd1:    k = 6'sd5;
            2'd2:    k = 6'sd20;
            default: k = 6'sd1;
        endcase
        return k;
    endfunction

    function automatic logic signed [5:0] f_kstep(input logic [1:0] ch, input logic [2:0] s);
        logic signed [5:0] k;
        k = 6'sd1;
        if (ch == 2'd1) begin
            case (s)
                3'd1:    k = 6'sd4;
                3'd2:    k = 6'sd3;
                3'd3:    k = 6'sd2;
                default: k = 6'sd1;
            endcase
        end else if (ch == 2'd2) begin
            case (s)
                3'd1:    k = 6'sd12;
                3'd2:    k = 6'sd6;
                default: k = 6'sd2;
            endcase
        end
        return k;
    endfunction

    function automatic logic [2:0] f_nstep(input logic [1:0] ch);
        logic [2:0] n;
        case (ch)
            2'd1:    n = 3'd4;
            2'd2:    n = 3'd3;
            default: n = 3'd5;
        endcase
        return n;
    endfunction

endpackage

// ----- rtl/qtg_mul.sv -----
// Scaled multiply: round(x * y / 2^sh) on magnitudes, half away from zero,
// saturated to the internal range. One 32x33 multiplier used twice.
module qtg_mul import qtg_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_val        i_x,
    input  logic [32:0] i_y,
    input  logic        i_sh32,
    output logic        o_done,
    output t_val        o_res
);

    localparam int FW = 97;

    logic [2:0]    r_ph;
    logic          r_done;
    logic          r_neg;
    logic [60:0]   r_m;
    logic [32:0]   r_y;
    logic          r_sh32;
    logic [64:0]   r_lo;
    logic [64:0]   r_hi;
    logic [FW-1:0] r_full;
    t_val          r_res;

    logic [31:0]   mul_a;
    logic [64:0]   prod;
    t_val          x_abs;
    logic [FW-1:0] shifted;
    logic          rbit;
    logic [FW-1:0] rsum;
    t_val          mag;

    // Low word of the magnitude first, then the high word.
    assign mul_a = (r_ph == 3'd1) ? r_m[31:0] : {3'b0, r_m[60:32]};
    assign prod  = {33'b0, mul_a} * {32'b0, r_y};
    assign x_abs = (i_x < 0) ? -i_x : i_x;

    // Rescale, round and saturate the assembled product.
    always_comb begin
        shifted = r_sh32 ? (r_full >> TAU_BITS) : (r_full >> FRAC_BITS);
        rbit    = r_sh32 ? r_full[TAU_BITS-1] : r_full[FRAC_BITS-1];
        rsum    = shifted + FW'(rbit);
        mag     = (rsum > FW'(SAT_MAG)) ? SAT_MAG : t_val'(rsum[63:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_ph)
                3'd0: begin
                    if (i_start) begin
                        r_ph <= 3'd1;
                    end
                end
                3'd4: begin
                    r_ph   <= 3'd0;
                    r_done <= 1'b1;
                end
                default: begin
                    r_ph <= r_ph + 3'd1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ph == 3'd0 && i_start) begin
            r_neg  <= i_x < 0;
            r_m    <= x_abs[60:0];
            r_y    <= i_y;
            r_sh32 <= i_sh32;
        end
        if (r_ph == 3'd1) begin
            r_lo <= prod;
        end
        if (r_ph == 3'd2) begin
            r_hi <= prod;
        end
        if (r_ph == 3'd3) begin
            r_full <= {r_hi, 32'b0} + FW'(r_lo);
        end
        if (r_ph == 3'd4) begin
            r_res <= r_neg ? -mag : mag;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ----- rtl/qtg_div.sv -----
// Restoring divider, one quotient bit per cycle. The quotient saturates
// to 2^61 - 1.
module qtg_div import qtg_pkg::*; #(
    parameter int DIVN_W = 63 + FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVN_W-1:0] i_num,
    input  logic [30:0]       i_den,
    output logic              o_done,
    output logic [60:0]       o_quo
);

    localparam int CW = $clog2(DIVN_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DIVN_W-1:0] r_num;
    logic [30:0]       r_rem;
    logic [30:0]       r_den;

    logic [31:0]       sh;
    logic [32:0]       diff;
    logic              ge;

    // Trial subtraction of the divisor from the shifted remainder.
    assign sh   = {r_rem, r_num[DIVN_W-1]};
    assign diff = {1'b0, sh} - {2'b0, r_den};
    assign ge   = !diff[32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= CW'(DIVN_W);
        end else if (r_busy) begin
            r_rem <= ge ? diff[30:0] : sh[30:0];
            r_num <= {r_num[DIVN_W-2:0], ge};
            r_cnt <= r_cnt - CW'(1);
        end
    end

    assign o_done = r_done;
    assign o_quo  = (|r_num[DIVN_W-1:61]) ? '1 : r_num[60:0];

endmodule

// ----- rtl/quintic_trajectory_generator_core.sv -----
// Piecewise quintic trajectory generator, signed fixed point with FRAC_BITS
// fraction bits. Items are handled one at a time; the input stalls while an
// item is in work, and one finished result can wait in the output register
// while the next item is taken. Begin items, rejected appends, the first
// waypoint and evaluates or ticks with fewer than two waypoints use neither
// the multiplier nor the divider. An append that closes a segment runs six
// scaled multiplies and then the coefficient writes. An evaluate scans the
// end-time entries, runs one phase division, reads the six coefficients,
// runs twelve Horner multiply steps and, unless the time lies past the last
// waypoint, three more divisions. The divider is serial and the multiplier
// is shared. The tables are not cleared at reset; only entries below the
// waypoint count are ever read.
module quintic_trajectory_generator_core import qtg_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [30:0] i_cfg_data
);

    localparam int PT_W       = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COEF_DEPTH = MAX_POINTS * 6;
    localparam int CA_W       = $clog2(COEF_DEPTH);
    localparam int DIVN_W     = 63 + FRAC_BITS;
    localparam logic [30:0] TS_RESET = 31'(((1 << FRAC_BITS) + 500) / 1000);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_APP_CHK  = 5'd1;
    localparam logic [4:0] S_MUL_GO   = 5'd2;
    localparam logic [4:0] S_MUL_W    = 5'd3;
    localparam logic [4:0] S_COEF_A   = 5'd4;
    localparam logic [4:0] S_COEF_B   = 5'd5;
    localparam logic [4:0] S_APP_END  = 5'd6;
    localparam logic [4:0] S_SRCH_RD  = 5'd7;
    localparam logic [4:0] S_SRCH_CHK = 5'd8;
    localparam logic [4:0] S_TAU_GO   = 5'd9;
    localparam logic [4:0] S_TAU_W    = 5'd10;
    localparam logic [4:0] S_CRD      = 5'd11;
    localparam logic [4:0] S_CRD_W    = 5'd12;
    localparam logic [4:0] S_HOR_INIT = 5'd13;
    localparam logic [4:0] S_DIV_GO   = 5'd14;
    localparam logic [4:0] S_DIV_W    = 5'd15;
    localparam logic [4:0] S_FIN      = 5'd16;

    // Control state.
    logic [4:0]         r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [31:0]        r_rt;
    logic [30:0]        r_step;
    logic               r_abs;
    logic [30:0]        r_last_end;
    logic signed [31:0] r_pw_p;
    logic signed [31:0] r_pw_v;
    logic signed [31:0] r_pw_a;
    logic               r_out_valid;
    t_out               r_out;

    // Item work registers.
    t_in                r_in;
    logic               r_eval;
    logic [30:0]        r_end;
    logic [30:0]        r_dur;
    logic [30:0]        r_period;
    logic [31:0]        r_t;
    logic [31:0]        r_pend;
    logic               r_past;
    logic [PT_W-1:0]    r_idx;
    logic [CA_W-1:0]    r_base;
    logic [2:0]         r_ms;
    logic [2:0]         r_k;
    logic [1:0]         r_ch;
    logic [2:0]         r_s;
    logic [1:0]         r_dsel;
    logic               r_dneg;
    logic [32:0]        r_tau;
    t_val               r_v0;
    t_val               r_v1;
    t_val               r_a0;
    t_val               r_a1;
    t_val               r_tmp;
    t_val               r_t1;
    t_val               r_t2;
    t_val               r_t3;
    t_val               r_acc;
    t_val               r_d1;
    t_val               r_d2;
    t_val               r_c [6];
    t_val               r_o_pos;
    t_val               r_o_vel;
    t_val               r_o_acc;
    logic [1:0]         r_o_st;

    // Memories and their read registers.
    logic [63:0]        m_coef [COEF_DEPTH];
    logic [31:0]        m_end [MAX_POINTS];
    logic [63:0]        r_coef_rd;
    logic [31:0]        r_end_rd;

    logic               in_acc;
    logic               out_acc;
    logic               out_load;
    logic [32:0]        nt;
    logic [31:0]        end_rel;
    logic [31:0]        dur;
    t_val               wp_diff;
    t_val               n_coef;
    logic               coef_we;
    logic [CA_W-1:0]    coef_wa;
    logic [63:0]        coef_wd;
    logic [CA_W-1:0]    coef_ra;
    logic               end_we;
    logic [PT_W-1:0]    end_wa;
    logic [31:0]        end_wd;
    logic [31:0]        seg_len;
    logic [CA_W-1:0]    seg_base;
    t_val               mul_x;
    logic [32:0]        mul_y;
    logic               mul_start;
    logic               mul_done;
    t_val               mul_res;
    t_val               hor_next;
    t_val               div_x;
    t_val               div_abs;
    logic               div_start;
    logic [DIVN_W-1:0]  div_num;
    logic               div_done;
    logic [60:0]        div_quo;
    t_val               div_q;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign out_acc     = r_out_valid && !i_out_stall;
    assign out_load    = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Running time advance, and the end time of an appended waypoint.
    assign nt      = {1'b0, r_rt} + {2'b0, r_step};
    assign end_rel = {1'b0, r_last_end} + {1'b0, i_in.time_value};
    assign dur     = {1'b0, r_end} - {1'b0, r_last_end};
    assign wp_diff = t_val'(r_pw_p) - t_val'(r_in.position);

    // Segment length from the scanned end times.
    assign seg_len  = r_end_rd - r_pend;
    assign seg_base = (CA_W'(r_idx) << 2) + (CA_W'(r_idx) << 1);

    // Coefficient memory write side.
    always_comb begin
        n_coef = f_sadd(f_sadd(r_t1, r_t2), r_t3);
        coef_we = 1'b0;
        coef_wd = 64'(n_coef);
        if (r_state == S_COEF_B) begin
            coef_we = 1'b1;
            coef_wd = (r_k == 3'd1) ? f_half(n_coef) : -f_half(n_coef);
        end else if (r_state == S_COEF_A && r_k >= 3'd3) begin
            coef_we = 1'b1;
            case (r_k)
                3'd3:    coef_wd = f_half(r_a0);
                3'd4:    coef_wd = r_v0;
                default: coef_wd = t_val'(r_pw_p);
            endcase
        end
    end
    assign coef_wa = r_base + CA_W'(r_k);
    assign coef_ra = r_base + CA_W'(r_k);

    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            m_coef[coef_wa] <= coef_wd;
        end
        r_coef_rd <= m_coef[coef_ra];
    end

    // End-time memory: written for the first waypoint and on each accepted append.
    always_comb begin
        end_we = 1'b0;
        end_wa = r_cnt[PT_W-1:0];
        end_wd = {1'b0, r_end};
        if (in_acc && i_in.opcode == OP_APPEND && r_cnt == '0) begin
            end_we = 1'b1;
            end_wa = '0;
            end_wd = '0;
        end else if (r_state == S_APP_END) begin
            end_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (end_we) begin
            m_end[end_wa] <= end_wd;
        end
        r_end_rd <= m_end[r_idx];
    end

    // Shared scaled multiplier operands.
    always_comb begin
        if (r_eval) begin
            mul_x = r_acc;
        end else begin
            case (r_ms)
                3'd0:    mul_x = t_val'(r_pw_v);
                3'd1:    mul_x = t_val'(r_in.velocity);
                3'd2:    mul_x = t_val'(r_pw_a);
                3'd4:    mul_x = t_val'(r_in.acceleration);
                default: mul_x = r_tmp;
            endcase
        end
    end
    assign mul_y     = r_eval ? r_tau : {2'b0, r_dur};
    assign mul_start = (r_state == S_MUL_GO);
    assign hor_next  = f_sadd(mul_res, f_smul(r_c[r_s], f_kstep(r_ch, r_s)));

    qtg_mul #(
        .FRAC_BITS(FRAC_BITS)
    ) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mul_start),
        .i_x    (mul_x),
        .i_y    (mul_y),
        .i_sh32 (r_eval),
        .o_done (mul_done),
        .o_res  (mul_res)
    );

    // Divider operands: the phase, or a rounded division by the duration.
    always_comb begin
        case (r_dsel)
            2'd0:    div_x = r_d1;
            2'd1:    div_x = r_d2;
            default: div_x = r_tmp;
        endcase
        div_abs = (div_x < 0) ? -div_x : div_x;
        if (r_state == S_TAU_GO) begin
            div_num = DIVN_W'({r_period, 32'b0});
        end else begin
            div_num = (DIVN_W'(div_abs[60:0]) << FRAC_BITS) + DIVN_W'(r_dur >> 1);
        end
    end
    assign div_start = (r_state == S_TAU_GO) || (r_state == S_DIV_GO);
    assign div_q     = r_dneg ? -t_val'({3'b0, div_quo}) : t_val'({3'b0, div_quo});

    qtg_div #(
        .DIVN_W(DIVN_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (r_dur),
        .o_done (div_done),
        .o_quo  (div_quo)
    );

    // Control state, configuration and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_rt        <= '0;
            r_step      <= TS_RESET;
            r_abs       <= 1'b0;
            r_last_end  <= '0;
            r_pw_p      <= '0;
            r_pw_v      <= '0;
            r_pw_a      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TIME_STEP: r_step <= i_cfg_data;
                    default:       r_abs  <= i_cfg_data[0];
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (i_in.opcode)
                            OP_BEGIN: begin
                                r_cnt   <= '0;
                                r_rt    <= {1'b0, i_in.time_value};
                                r_state <= S_FIN;
                            end
                            OP_APPEND: begin
                                if (r_cnt == CNT_W'(MAX_POINTS)) begin
                                    r_state <= S_FIN;
                                end else if (r_cnt == '0) begin
                                    r_last_end <= '0;
                                    r_pw_p     <= i_in.position;
                                    r_pw_v     <= i_in.velocity;
                                    r_pw_a     <= i_in.acceleration;
                                    r_cnt      <= CNT_W'(1);
                                    r_state    <= S_FIN;
                                end else begin
                                    r_state <= S_APP_CHK;
                                end
                            end
                            OP_EVAL: begin
                                r_state <= (r_cnt < CNT_W'(2)) ? S_FIN : S_SRCH_RD;
                            end
                            default: begin
                                r_rt    <= nt[32] ? '1 : nt[31:0];
                                r_state <= (r_cnt < CNT_W'(2)) ? S_FIN : S_SRCH_RD;
                            end
                        endcase
                    end
                end
                S_APP_CHK: begin
                    r_state <= (dur[31] || dur == '0) ? S_FIN : S_MUL_GO;
                end
                S_MUL_GO: begin
                    r_state <= S_MUL_W;
                end
                S_MUL_W: begin
                    if (mul_done) begin
                        if (!r_eval) begin
                            r_state <= (r_ms == 3'd5) ? S_COEF_A : S_MUL_GO;
                        end else if (r_s == f_nstep(r_ch)) begin
                            if (r_ch == 2'd2) begin
                                r_state <= r_past ? S_FIN : S_DIV_GO;
                            end else begin
                                r_state <= S_HOR_INIT;
                            end
                        end else begin
                            r_state <= S_MUL_GO;
                        end
                    end
                end
                S_COEF_A: begin
                    if (r_k < 3'd3) begin
                        r_state <= S_COEF_B;
                    end else if (r_k == 3'd5) begin
                        r_state <= S_APP_END;
                    end
                end
                S_COEF_B: begin
                    r_state <= S_COEF_A;
                end
                S_APP_END: begin
                    r_last_end <= r_end;
                    r_pw_p     <= r_in.position;
                    r_pw_v     <= r_in.velocity;
                    r_pw_a     <= r_in.acceleration;
                    r_cnt      <= r_cnt + CNT_W'(1);
                    r_state    <= S_FIN;
                end
                S_SRCH_RD: begin
                    r_state <= S_SRCH_CHK;
                end
                S_SRCH_CHK: begin
                    if (r_idx != '0 && (r_t <= r_end_rd ||
                            CNT_W'(r_idx) == r_cnt - CNT_W'(1))) begin
                        r_state <= S_TAU_GO;
                    end else begin
                        r_state <= S_SRCH_RD;
                    end
                end
                S_TAU_GO: begin
                    r_state <= S_TAU_W;
                end
                S_TAU_W: begin
                    if (div_done) begin
                        r_state <= S_CRD;
                    end
                end
                S_CRD: begin
                    r_state <= S_CRD_W;
                end
                S_CRD_W: begin
                    r_state <= (r_k == 3'd5) ? S_HOR_INIT : S_CRD;
                end
                S_HOR_INIT: begin
                    r_state <= S_MUL_GO;
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_W;
                end
                S_DIV_W: begin
                    if (div_done) begin
                        r_state <= (r_dsel == 2'd2) ? S_FIN : S_DIV_GO;
                    end
                end
                S_FIN: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers of the item in work.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.out_position     <= f_out32(r_o_pos);
            r_out.out_velocity     <= f_out32(r_o_vel);
            r_out.out_acceleration <= f_out32(r_o_acc);
            r_out.status           <= r_o_st;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_in    <= i_in;
                    r_eval  <= 1'b0;
                    r_past  <= 1'b0;
                    r_idx   <= '0;
                    r_ms    <= '0;
                    r_k     <= '0;
                    r_o_pos <= '0;
                    r_o_vel <= '0;
                    r_o_acc <= '0;
                    r_o_st  <= ST_OK;
                    r_end   <= r_abs ? i_in.time_value :
                               (end_rel[31] ? TIME_MAX : end_rel[30:0]);
                    r_t     <= {1'b0, i_in.time_value};
                    if (i_in.opcode == OP_TICK) begin
                        r_t <= nt[32] ? '1 : nt[31:0];
                    end
                    if (i_in.opcode == OP_APPEND && r_cnt == CNT_W'(MAX_POINTS)) begin
                        r_o_st <= ST_FULL;
                    end
                    if ((i_in.opcode == OP_EVAL || i_in.opcode == OP_TICK) &&
                            r_cnt < CNT_W'(2)) begin
                        r_o_st <= ST_FEW;
                    end
                end
            end
            S_APP_CHK: begin
                r_dur  <= dur[30:0];
                r_base <= (CA_W'(r_cnt) << 2) + (CA_W'(r_cnt) << 1);
                if (dur[31] || dur == '0) begin
                    r_o_st <= ST_NONPOS;
                end
            end
            S_MUL_W: begin
                if (mul_done) begin
                    if (!r_eval) begin
                        case (r_ms)
                            3'd0:    r_v0  <= mul_res;
                            3'd1:    r_v1  <= mul_res;
                            3'd3:    r_a0  <= mul_res;
                            3'd5:    r_a1  <= mul_res;
                            default: r_tmp <= mul_res;
                        endcase
                        r_ms <= r_ms + 3'd1;
                    end else if (r_s == f_nstep(r_ch)) begin
                        case (r_ch)
                            2'd0:    r_o_pos <= hor_next;
                            2'd1:    r_d1    <= hor_next;
                            default: r_d2    <= hor_next;
                        endcase
                        r_ch   <= r_ch + 2'd1;
                        r_dsel <= 2'd0;
                    end else begin
                        r_acc <= hor_next;
                        r_s   <= r_s + 3'd1;
                    end
                end
            end
            S_COEF_A: begin
                // First half of a coefficient: two partial sums and a tail term.
                case (r_k)
                    3'd0: begin
                        r_t1 <= f_sadd(f_smul(wp_diff, 6'sd12), f_smul(r_v0, 6'sd6));
                        r_t2 <= f_sadd(f_smul(r_v1, 6'sd6), r_a0);
                        r_t3 <= -r_a1;
                    end
                    3'd1: begin
                        r_t1 <= f_sadd(f_smul(wp_diff, 6'sd30), f_smul(r_v0, 6'sd16));
                        r_t2 <= f_sadd(f_smul(r_v1, 6'sd14), f_smul(r_a0, 6'sd3));
                        r_t3 <= f_smul(r_a1, -6'sd2);
                    end
                    3'd2: begin
                        r_t1 <= f_sadd(f_smul(wp_diff, 6'sd20), f_smul(r_v0, 6'sd12));
                        r_t2 <= f_sadd(f_smul(r_v1, 6'sd8), f_smul(r_a0, 6'sd3));
                        r_t3 <= -r_a1;
                    end
                    default: begin
                        r_k <= r_k + 3'd1;
                    end
                endcase
            end
            S_COEF_B: begin
                r_k <= r_k + 3'd1;
            end
            S_SRCH_CHK: begin
                // Scan end times for the first segment that ends at or after t.
                r_pend <= r_end_rd;
                r_idx  <= r_idx + PT_W'(1);
                r_eval <= 1'b1;
                r_dur  <= seg_len[30:0];
                r_base <= seg_base;
                r_k    <= '0;
                r_ch   <= '0;
                if (r_idx != '0) begin
                    if (r_t <= r_end_rd) begin
                        r_idx    <= r_idx;
                        r_pend   <= r_pend;
                        r_period <= 31'(r_t - r_pend);
                    end else if (CNT_W'(r_idx) == r_cnt - CNT_W'(1)) begin
                        r_idx    <= r_idx;
                        r_pend   <= r_pend;
                        r_past   <= 1'b1;
                        r_period <= seg_len[30:0];
                    end
                end
            end
            S_TAU_W: begin
                if (div_done) begin
                    r_tau <= div_quo[32:0];
                end
            end
            S_CRD_W: begin
                r_c[r_k] <= t_val'(r_coef_rd);
                r_k      <= r_k + 3'd1;
            end
            S_HOR_INIT: begin
                r_acc <= f_smul(r_c[0], f_kinit(r_ch));
                r_s   <= 3'd1;
            end
            S_DIV_GO: begin
                r_dneg <= div_x < 0;
            end
            S_DIV_W: begin
                if (div_done) begin
                    case (r_dsel)
                        2'd0:    r_o_vel <= div_q;
                        2'd1:    r_tmp   <= div_q;
                        default: r_o_acc <= div_q;
                    endcase
                    r_dsel <= r_dsel + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import qtg_pkg::*;

    localparam int FRAC      = FRAC_BITS_DEF;
    localparam int NPTS      = MAX_POINTS_DEF;
    localparam int SETTLE    = 700;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in         in_beat;
    logic        out_valid;
    logic        out_stall;
    t_out        out_beat;
    logic        cfg_we;
    logic        cfg_idx;
    logic [30:0] cfg_data;

    quintic_trajectory_generator_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Pending input beats, expected results and run status.
    t_in  pending_beats[$];
    t_out expected_results[$];
    int   error_count;
    bit   calm;
    bit   hold_request;
    bit   hold_done;

    // Shadow of the generator state.
    logic [31:0] seg_end [NPTS];
    longint      seg_coef[NPTS*6];
    longint      last_pos, last_vel, last_acc;
    int          point_count;
    logic [31:0] run_time;
    logic [30:0] step_size;
    bit          abs_mode;

    // Saturate a wide value to the internal range.
    function automatic longint sat_int(input logic signed [127:0] x);
        longint r;
        if (x > 128'(SAT_MAG)) begin
            r = SAT_MAG;
        end else if (x < -128'(SAT_MAG)) begin
            r = -SAT_MAG;
        end else begin
            r = x[63:0];
        end
        return r;
    endfunction

    function automatic longint add_sat(input longint a, input longint b);
        logic signed [127:0] w;
        w = a;
        w = w + b;
        return sat_int(w);
    endfunction

    function automatic longint mul_sat(input longint x, input int k);
        logic signed [127:0] w;
        w = x;
        w = w * k;
        return sat_int(w);
    endfunction

    function automatic longint halve(input longint x);
        longint r;
        if (x >= 0) begin
            r = (x + 1) / 2;
        end else begin
            r = -((-x + 1) / 2);
        end
        return r;
    endfunction

    // Scaled product, rounded half away from zero: x * y / 2^sh.
    function automatic longint scale_mul(input longint x, input logic [32:0] y, input int sh);
        logic [127:0] m;
        logic [127:0] p;
        longint       r;
        m = (x < 0) ? -x : x;
        p = m * y;
        p = (p + (128'd1 << (sh - 1))) >> sh;
        if (p > 128'(SAT_MAG)) p = 128'(SAT_MAG);
        r = p[63:0];
        return (x < 0) ? -r : r;
    endfunction

    // Rounded division of x * 2^FRAC by d.
    function automatic longint scale_div(input longint x, input logic [31:0] d);
        logic [127:0] m;
        logic [127:0] q;
        longint       r;
        m = (x < 0) ? -x : x;
        q = ((m << FRAC) + (d / 2)) / d;
        if (q > 128'(SAT_MAG)) q = 128'(SAT_MAG);
        r = q[63:0];
        return (x < 0) ? -r : r;
    endfunction

    function automatic logic signed [31:0] clip32(input longint x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Add a waypoint and build the quintic of the segment it closes.
    function automatic void add_waypoint(input t_in it, inout t_out res);
        logic [31:0] prev_end;
        logic [31:0] new_end;
        longint      dur;
        longint      v0, v1, a0, a1, dp, n;
        int          b;
        if (point_count >= NPTS) begin
            res.status = ST_FULL;
            return;
        end
        if (point_count == 0) begin
            seg_end[0] = 0;
        end else begin
            prev_end = seg_end[point_count-1];
            if (abs_mode) begin
                new_end = {1'b0, it.time_value};
            end else begin
                new_end = prev_end + it.time_value;
                if (new_end > {1'b0, TIME_MAX}) new_end = {1'b0, TIME_MAX};
            end
            dur = longint'(new_end) - longint'(prev_end);
            if (dur <= 0) begin
                res.status = ST_NONPOS;
                return;
            end
            v0 = scale_mul(last_vel, dur, FRAC);
            v1 = scale_mul(longint'(it.velocity), dur, FRAC);
            a0 = scale_mul(scale_mul(last_acc, dur, FRAC), dur, FRAC);
            a1 = scale_mul(scale_mul(longint'(it.acceleration), dur, FRAC), dur, FRAC);
            dp = last_pos - longint'(it.position);
            b  = point_count * 6;
            n = add_sat(add_sat(add_sat(mul_sat(dp, 12), mul_sat(v0, 6)),
                                add_sat(mul_sat(v1, 6), a0)), -a1);
            seg_coef[b] = -halve(n);
            n = add_sat(add_sat(add_sat(mul_sat(dp, 30), mul_sat(v0, 16)),
                                add_sat(mul_sat(v1, 14), mul_sat(a0, 3))), mul_sat(a1, -2));
            seg_coef[b+1] = halve(n);
            n = add_sat(add_sat(add_sat(mul_sat(dp, 20), mul_sat(v0, 12)),
                                add_sat(mul_sat(v1, 8), mul_sat(a0, 3))), -a1);
            seg_coef[b+2] = -halve(n);
            seg_coef[b+3] = halve(a0);
            seg_coef[b+4] = v0;
            seg_coef[b+5] = last_pos;
            seg_end[point_count] = new_end;
        end
        last_pos = it.position;
        last_vel = it.velocity;
        last_acc = it.acceleration;
        point_count++;
        res.status = ST_OK;
    endfunction

    // Position, velocity and acceleration at time t.
    function automatic void sample_at(input logic [31:0] t, inout t_out res);
        int          seg;
        int          b;
        bit          past;
        logic [31:0] d;
        logic [63:0] period;
        logic [32:0] tau;
        longint      pos, d1, d2;
        seg = 0;
        if (point_count < 2) begin
            res.status = ST_FEW;
            return;
        end
        for (int i = 1; i < point_count; i++) begin
            if (seg == 0 && t <= seg_end[i]) seg = i;
        end
        past = (seg == 0);
        if (past) seg = point_count - 1;
        d = seg_end[seg] - seg_end[seg-1];
        period = past ? d : t - seg_end[seg-1];
        tau = (period << TAU_BITS) / d;
        b = seg * 6;
        pos = seg_coef[b];
        for (int i = 1; i < 6; i++) pos = add_sat(scale_mul(pos, tau, TAU_BITS), seg_coef[b+i]);
        d1 = mul_sat(seg_coef[b], 5);
        d1 = add_sat(scale_mul(d1, tau, TAU_BITS), mul_sat(seg_coef[b+1], 4));
        d1 = add_sat(scale_mul(d1, tau, TAU_BITS), mul_sat(seg_coef[b+2], 3));
        d1 = add_sat(scale_mul(d1, tau, TAU_BITS), mul_sat(seg_coef[b+3], 2));
        d1 = add_sat(scale_mul(d1, tau, TAU_BITS), seg_coef[b+4]);
        d2 = mul_sat(seg_coef[b], 20);
        d2 = add_sat(scale_mul(d2, tau, TAU_BITS), mul_sat(seg_coef[b+1], 12));
        d2 = add_sat(scale_mul(d2, tau, TAU_BITS), mul_sat(seg_coef[b+2], 6));
        d2 = add_sat(scale_mul(d2, tau, TAU_BITS), mul_sat(seg_coef[b+3], 2));
        res.out_position = clip32(pos);
        if (!past) begin
            res.out_velocity     = clip32(scale_div(d1, d));
            res.out_acceleration = clip32(scale_div(scale_div(d2, d), d));
        end
        res.status = ST_OK;
    endfunction

    // Expected result of one accepted beat; updates the shadow state.
    function automatic t_out trajectory_result(input t_in it);
        t_out        res;
        logic [32:0] nt;
        res = '0;
        case (it.opcode)
            OP_BEGIN: begin
                point_count = 0;
                run_time = {1'b0, it.time_value};
            end
            OP_APPEND: add_waypoint(it, res);
            OP_EVAL: sample_at({1'b0, it.time_value}, res);
            default: begin
                nt = run_time + step_size;
                run_time = nt[32] ? 32'hFFFF_FFFF : nt[31:0];
                sample_at(run_time, res);
            end
        endcase
        return res;
    endfunction

    // Input driver: offers pending beats with random gaps.
    int gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else if (!(in_valid && in_stall)) begin
            if (in_valid) expected_results.push_back(trajectory_result(in_beat));
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                if (!calm && $urandom_range(0, 19) == 0) begin
                    gap_left <= $urandom_range(0, 11);
                    in_valid <= 1'b0;
                end else begin
                    in_beat  <= pending_beats.pop_front();
                    in_valid <= 1'b1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result monitor with random and long output stalls.
    int stall_left;
    always @(posedge i_clk) begin
        t_out exp_res;
        if (!i_rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
            hold_done  <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected: %h", $realtime, out_beat);
                    error_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (out_beat.out_position !== exp_res.out_position) begin
                        $display("%0t: position expected %0d actual %0d", $realtime,
                                 exp_res.out_position, out_beat.out_position);
                        error_count++;
                    end
                    if (out_beat.out_velocity !== exp_res.out_velocity) begin
                        $display("%0t: velocity expected %0d actual %0d", $realtime,
                                 exp_res.out_velocity, out_beat.out_velocity);
                        error_count++;
                    end
                    if (out_beat.out_acceleration !== exp_res.out_acceleration) begin
                        $display("%0t: acceleration expected %0d actual %0d", $realtime,
                                 exp_res.out_acceleration, out_beat.out_acceleration);
                        error_count++;
                    end
                    if (out_beat.status !== exp_res.status) begin
                        $display("%0t: status expected %0d actual %0d", $realtime,
                                 exp_res.status, out_beat.status);
                        error_count++;
                    end
                end
            end
            if (hold_request && !hold_done) begin
                hold_done  <= 1'b1;
                stall_left <= 4000;
                out_stall  <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                out_stall  <= 1'b1;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                stall_left <= $urandom_range(0, 11);
                out_stall  <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Timeout.
    initial begin
        #50_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0: v = $urandom;
            1: v = 32'sh8000_0000;
            2: v = 32'sh7FFF_FFFF;
            3: v = 0;
            default: v = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
        endcase
        return v;
    endfunction

    function automatic void queue_beat(input logic [1:0] op, input logic [30:0] tv);
        t_in it;
        it.opcode       = op;
        it.time_value   = tv;
        it.position     = pick_value();
        it.velocity     = pick_value();
        it.acceleration = pick_value();
        pending_beats.push_back(it);
    endfunction

    task automatic wait_idle();
        while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [30:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx == CFG_TIME_STEP) step_size = data;
        else abs_mode = data[0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Random trajectories: a begin, a run of waypoints, then samples and ticks.
    task automatic random_phase(input int n_beats);
        int          made;
        int          npts;
        longint      t_now;
        logic [30:0] tv;
        made = 0;
        while (made < n_beats) begin
            queue_beat(OP_BEGIN, ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                           : 31'($urandom_range(0, 65536)));
            npts  = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 6);
            t_now = 0;
            made += 1 + npts;
            for (int i = 0; i < npts; i++) begin
                case ($urandom_range(0, 29))
                    0: tv = 0;
                    1: tv = $urandom;
                    2: tv = abs_mode ? 31'($urandom_range(0, 32'(t_now))) : TIME_MAX;
                    default: tv = $urandom_range(1, 131072);
                endcase
                if (abs_mode && tv != 0 && i > 0 && tv < 131073) tv = 31'(t_now + tv);
                queue_beat(OP_APPEND, tv);
                if (i == 0) t_now = 0;
                else if (abs_mode) t_now = (tv > t_now) ? tv : t_now;
                else t_now = (t_now + tv > TIME_MAX) ? TIME_MAX : t_now + tv;
            end
            for (int i = $urandom_range(1, 8); i > 0; i--) begin
                case ($urandom_range(0, 9))
                    0: queue_beat(OP_EVAL, $urandom);
                    1, 2, 3: queue_beat(OP_TICK, $urandom);
                    default: queue_beat(OP_EVAL, 31'($urandom_range(0, 32'(t_now) + 4096)));
                endcase
                made++;
            end
        end
    endtask

    // Stimulus sequence.
    initial begin
        error_count  = 0;
        calm         = 1'b0;
        hold_request = 1'b0;
        point_count  = 0;
        last_pos     = 0;
        last_vel     = 0;
        last_acc     = 0;
        run_time     = 0;
        step_size    = 31'd66;
        abs_mode     = 1'b0;
        in_beat      = '0;
        in_valid     = 1'b0;
        out_stall    = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_TIME_STEP;
        cfg_data     = '0;
        i_rst_n      = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: too few points, first waypoint time ignored, zero and
        // overflowing durations, samples inside, at the ends and past the end.
        queue_beat(OP_EVAL, 31'd0);
        queue_beat(OP_TICK, 31'd0);
        queue_beat(OP_BEGIN, TIME_MAX);
        queue_beat(OP_APPEND, TIME_MAX);
        queue_beat(OP_EVAL, 31'd100);
        queue_beat(OP_APPEND, 31'd0);
        queue_beat(OP_APPEND, 31'd65536);
        queue_beat(OP_APPEND, 31'd1);
        queue_beat(OP_APPEND, TIME_MAX);
        queue_beat(OP_APPEND, 31'd5);
        queue_beat(OP_EVAL, 31'd0);
        queue_beat(OP_EVAL, 31'd32768);
        queue_beat(OP_EVAL, 31'd65536);
        queue_beat(OP_EVAL, 31'd65537);
        queue_beat(OP_EVAL, TIME_MAX);
        queue_beat(OP_TICK, 31'd0);
        queue_beat(OP_BEGIN, 31'd0);
        queue_beat(OP_TICK, 31'd0);
        queue_beat(OP_APPEND, 31'd0);
        queue_beat(OP_APPEND, 31'd1);
        queue_beat(OP_EVAL, 31'd1);
        queue_beat(OP_TICK, 31'd0);
        wait_idle();

        random_phase(380);
        wait_idle();

        // Absolute times and a zero step; the receiver holds off at the start.
        write_reg(CFG_ABS_TIMES, 31'd1);
        write_reg(CFG_TIME_STEP, 31'd0);
        hold_request = 1'b1;
        random_phase(380);
        wait_idle();

        // Largest step drives the running time into saturation.
        write_reg(CFG_ABS_TIMES, 31'd0);
        write_reg(CFG_TIME_STEP, TIME_MAX);
        queue_beat(OP_BEGIN, TIME_MAX);
        queue_beat(OP_TICK, 31'd0);
        queue_beat(OP_TICK, 31'd0);
        random_phase(380);
        wait_idle();

        write_reg(CFG_ABS_TIMES, 31'd1);
        write_reg(CFG_TIME_STEP, 31'($urandom_range(1, 20000)));
        random_phase(300);
        wait_idle();

        // Last part runs without idling on either side.
        write_reg(CFG_ABS_TIMES, 31'd0);
        write_reg(CFG_TIME_STEP, 31'd1000);
        calm = 1'b1;
        random_phase(300);
        wait_idle();

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
